[rtl/core/afrs_pkg.sv]
// shared types, constants and codes for the audio fifo rate servo
`default_nettype none

package afrs_pkg;

  localparam int BUF_SAMPLES = 32768;

  localparam int OFS_W    = 15;
  localparam int PAIRS_W  = 15;
  localparam int COUNT_W  = 32;
  localparam int FUDGE_W  = 16;
  localparam int EVENT_W  = 2;
  localparam int THR_W    = 14;
  localparam int CFG_A_W  = 1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [COUNT_W-1:0] BUF_COUNT = COUNT_W'(BUF_SAMPLES);
  localparam logic [COUNT_W-1:0] BUF_MASK  = COUNT_W'(BUF_SAMPLES - 1);
  localparam logic [OFS_W-1:0]   HALF_BUF_PAIRS = OFS_W'(BUF_SAMPLES >> 1);
  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1024);

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  localparam logic [CFG_A_W-1:0] CFG_ENABLED = CFG_A_W'(0);
  localparam logic [CFG_A_W-1:0] CFG_LOW_THR = CFG_A_W'(1);

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 2'd0,
    EV_OVERFLOW  = 2'd1,
    EV_UNDERFLOW = 2'd2
  } event_t;

  // fill level status handed from the level tracker to the servo
  typedef struct packed {
    logic overflow;
    logic underflow;
    logic below_low;
    logic below_mid;
  } level_t;

endpackage

`default_nettype wire

[rtl/core/audio_fifo_rate_servo_top.sv]
// audio fifo rate servo: fill level tracker with signed rate correction
//
// Takes one item per cycle while out_tready lets results go: the item lands in an
// input register, the level tracker and servo evaluate it against the write
// count and correction value, and the answer is captured in the result
// register while a commit updates the state on that same edge, so the next
// item already sees it. The input register refills when empty or when its
// item moves on into a result register that is empty or being taken, so
// in_tready follows out_tready combinationally. Configuration writes are taken at any edge with cfg_we high.
`default_nettype none

module audio_fifo_rate_servo_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [afrs_pkg::CFG_A_W-1:0]       cfg_addr,
  input  wire logic [afrs_pkg::THR_W-1:0]         cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // num_pairs[14:0], read_count[46:15], zero pad[47]
  input  wire logic [afrs_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // write_offset[14:0], free_pairs[29:15], rate_fudge[45:30], event_res[47:46]
  output logic [afrs_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import afrs_pkg::*;

  logic                      enabled_r;
  logic [THR_W-1:0]          low_thr_r;
  logic [COUNT_W-1:0]        write_count_r;
  logic signed [FUDGE_W-1:0] fudge_r;

  logic                      in_vld_r;
  logic                      cmd_r;
  logic [PAIRS_W-1:0]        pairs_r;
  logic [COUNT_W-1:0]        rd_r;

  logic                      out_vld_r;
  logic [OFS_W-1:0]          wofs_r;
  logic [OFS_W-1:0]          free_r;
  logic signed [FUDGE_W-1:0] rfudge_r;
  event_t                    event_r;

  logic                      advance;
  logic                      commit;
  level_t                    level;
  logic [OFS_W-1:0]          q_wofs;
  logic [OFS_W-1:0]          q_free;
  logic [COUNT_W-1:0]        write_count_nxt;
  logic signed [FUDGE_W-1:0] fudge_nxt;
  event_t                    servo_event;

  logic [OFS_W-1:0]          wofs_nxt;
  logic [OFS_W-1:0]          free_nxt;
  logic signed [FUDGE_W-1:0] rfudge_nxt;
  event_t                    event_nxt;

  afrs_fill u_fill (
    .write_count     (write_count_r),
    .read_count      (rd_r),
    .num_pairs       (pairs_r),
    .low_threshold   (low_thr_r),
    .level           (level),
    .write_offset    (q_wofs),
    .free_pairs      (q_free),
    .write_count_nxt (write_count_nxt)
  );

  afrs_servo u_servo (
    .level     (level),
    .fudge     (fudge_r),
    .fudge_nxt (fudge_nxt),
    .event_res (servo_event)
  );

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign commit    = advance && (cmd_r == CMD_COMMIT) && enabled_r;

  always_comb begin
    wofs_nxt   = '0;
    free_nxt   = '0;
    rfudge_nxt = fudge_r;
    event_nxt  = EV_NONE;
    if (cmd_r == CMD_QUERY) begin
      if (enabled_r) begin
        wofs_nxt = q_wofs;
        free_nxt = q_free;
      end else begin
        free_nxt = HALF_BUF_PAIRS;
      end
    end else if (enabled_r) begin
      rfudge_nxt = fudge_nxt;
      event_nxt  = servo_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      low_thr_r <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLED: enabled_r <= cfg_wdata[0];
        CFG_LOW_THR: low_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_count_r <= BUF_COUNT;
      fudge_r       <= '0;
    end else if (commit) begin
      write_count_r <= write_count_nxt;
      fudge_r       <= fudge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser;
      pairs_r <= in_tdata[PAIRS_W-1:0];
      rd_r    <= in_tdata[PAIRS_W +: COUNT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wofs_r   <= wofs_nxt;
      free_r   <= free_nxt;
      rfudge_r <= rfudge_nxt;
      event_r  <= event_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {event_r, rfudge_r, free_r, wofs_r};

  // commit results carry no ring position
  a_event_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && event_r != EV_NONE) |-> (wofs_r == '0 && free_r == '0))
    else $error("event reported with nonzero offset or free pairs");

  // free space never exceeds half the ring
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ({1'b0, free_r} <= {1'b0, HALF_BUF_PAIRS}))
    else $error("free pairs above half the ring");

  // state only moves on an enabled commit
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> ($stable(fudge_r) && $stable(write_count_r)))
    else $error("servo state changed without a commit");

  // a delivered result carries the correction held in the state
  a_fudge_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (rfudge_r == fudge_r))
    else $error("reported correction differs from state");

endmodule

`default_nettype wire

[rtl/core/afrs_fill.sv]
// fill level tracker: query answer, commit flags and next write count
`default_nettype none

module afrs_fill (
  input  wire logic [afrs_pkg::COUNT_W-1:0] write_count,
  input  wire logic [afrs_pkg::COUNT_W-1:0] read_count,
  input  wire logic [afrs_pkg::PAIRS_W-1:0] num_pairs,
  input  wire logic [afrs_pkg::THR_W-1:0]   low_threshold,
  output afrs_pkg::level_t                  level,
  output logic [afrs_pkg::OFS_W-1:0]        write_offset,
  output logic [afrs_pkg::OFS_W-1:0]        free_pairs,
  output logic [afrs_pkg::COUNT_W-1:0]      write_count_nxt
);
  import afrs_pkg::*;

  localparam logic signed [COUNT_W:0] BUF_S = (COUNT_W+1)'(BUF_SAMPLES);

  logic        [COUNT_W-1:0] diff;
  logic signed [COUNT_W:0]   used;
  logic        [COUNT_W-1:0] ofs;
  logic signed [COUNT_W:0]   ofs_s;
  logic signed [COUNT_W:0]   top;
  logic signed [COUNT_W:0]   room;
  logic        [PAIRS_W:0]   n_samples;
  logic signed [COUNT_W:0]   ovf_level;
  logic        [THR_W+1:0]   thr3;

  always_comb begin
    diff      = write_count - read_count;
    used      = $signed({diff[COUNT_W-1], diff});
    ofs       = write_count & BUF_MASK;
    ofs_s     = $signed({1'b0, ofs});
    top       = (ofs_s > used) ? ofs_s : used;
    room      = BUF_S - top;
    n_samples = {num_pairs, 1'b0};
    ovf_level = BUF_S - $signed({{(COUNT_W-PAIRS_W){1'b0}}, n_samples});
    thr3      = {2'b00, low_threshold} + {1'b0, low_threshold, 1'b0};

    write_offset    = ofs[OFS_W-1:0];
    free_pairs      = (room > 0) ? room[OFS_W:1] : '0;
    write_count_nxt = write_count + COUNT_W'(n_samples);

    level.overflow  = (used == ovf_level);
    level.underflow = (used == '0);
    level.below_low = (used < $signed({{(COUNT_W+1-THR_W){1'b0}}, low_threshold}));
    level.below_mid = (used < $signed({{(COUNT_W-1-THR_W){1'b0}}, thr3}));
  end

endmodule

`default_nettype wire

[rtl/core/afrs_servo.sv]
// rate correction update from the fill level status
`default_nettype none

module afrs_servo (
  input  wire afrs_pkg::level_t                    level,
  input  wire logic signed [afrs_pkg::FUDGE_W-1:0] fudge,
  output logic signed [afrs_pkg::FUDGE_W-1:0]      fudge_nxt,
  output afrs_pkg::event_t                         event_res
);
  import afrs_pkg::*;

  localparam int W = FUDGE_W + 2;
  localparam logic signed [W-1:0] FMAX = W'((1 << (FUDGE_W - 1)) - 1);
  localparam logic signed [W-1:0] FMIN = -W'(1 << (FUDGE_W - 1));
  localparam logic signed [W-1:0] STEP_BIG   = W'(10);
  localparam logic signed [W-1:0] STEP_SMALL = W'(3);
  localparam logic signed [W-1:0] STEP_ONE   = W'(1);

  logic signed [W-1:0] f;
  logic signed [W-1:0] rounded;
  logic signed [W-1:0] half;
  logic signed [W-1:0] r;

  always_comb begin
    f       = W'(fudge);
    rounded = f + $signed({{(W-1){1'b0}}, fudge[FUDGE_W-1]});
    half    = rounded >>> 1;
    event_res = EV_NONE;
    if (level.overflow) begin
      event_res = EV_OVERFLOW;
      r = (f < -STEP_BIG) ? half : f + STEP_BIG;
    end else if (level.underflow) begin
      event_res = EV_UNDERFLOW;
      r = (f > STEP_BIG) ? half : f - STEP_BIG;
    end else if (level.below_low) begin
      r = f - STEP_SMALL;
    end else if (level.below_mid) begin
      r = f + STEP_SMALL;
    end else if (f > 0) begin
      r = f - STEP_ONE;
    end else if (f < 0) begin
      r = f + STEP_ONE;
    end else begin
      r = f;
    end

    if (r > FMAX) begin
      fudge_nxt = FMAX[FUDGE_W-1:0];
    end else if (r < FMIN) begin
      fudge_nxt = FMIN[FUDGE_W-1:0];
    end else begin
      fudge_nxt = r[FUDGE_W-1:0];
    end
  end

endmodule

`default_nettype wire
